/* design/load_cell_conditioner_unit_defines.svh */
// Assertion macros for the load cell conditioner unit.
// Included by every module that carries concurrent assertions; no other dependencies.
`ifndef LOAD_CELL_CONDITIONER_UNIT_DEFINES_SVH
`define LOAD_CELL_CONDITIONER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define LCC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LCC_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LCC_ASSERT(lbl, clk, rst_n, prop, msg)
`define LCC_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

/* design/lcc_pkg.sv */
// Shared types and constants of the load cell conditioner unit.
// Used by lcc_ctrl, lcc_datapath and the top level; no dependencies.
package lcc_pkg;

  localparam int CNT_W  = 32;
  localparam int WGT_W  = 48;
  localparam int DIFF_W = 33;
  localparam int PROD_W = 65;
  localparam int ALPHA_W = 9;
  localparam int LIMIT_W = 31;

  // request kinds
  localparam logic [1:0] REQ_NEW      = 2'd0;
  localparam logic [1:0] REQ_PEAK_RST = 2'd1;
  localparam logic [1:0] REQ_RESEED   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_ZERO_OFFSET  = 2'd0;
  localparam logic [1:0] CFG_SCALE_Q24    = 2'd1;
  localparam logic [1:0] CFG_ALPHA_Q8     = 2'd2;
  localparam logic [1:0] CFG_GLITCH_LIMIT = 2'd3;

  localparam logic signed [CNT_W-1:0] SCALE_RESET = 32'sd16777216;
  localparam logic [ALPHA_W-1:0]      ALPHA_RESET = 9'd64;
  localparam logic [ALPHA_W-1:0]      ALPHA_ONE   = 9'd256;
  localparam logic [LIMIT_W-1:0]      LIMIT_RESET = 31'd200000;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_STEP = 7'b0000010,
    S_UPD  = 7'b0000100,
    S_SUBF = 7'b0001000,
    S_MULF = 7'b0010000,
    S_MULP = 7'b0100000,
    S_DONE = 7'b1000000
  } lcc_state_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic upd;
    logic subf;
    logic mulf;
    logic mulp;
    logic load_out;
  } lcc_cmd_t;

endpackage

/* design/lcc_ctrl.sv */
// Sequencing controller of the load cell conditioner unit.
// Depends on lcc_pkg and load_cell_conditioner_unit_defines.svh.
`include "load_cell_conditioner_unit_defines.svh"

module lcc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output lcc_pkg::lcc_cmd_t cmd
);

  lcc_pkg::lcc_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == lcc_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      lcc_pkg::S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = lcc_pkg::S_STEP;
        end
      end
      lcc_pkg::S_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = lcc_pkg::S_UPD;
      end
      lcc_pkg::S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = lcc_pkg::S_SUBF;
      end
      lcc_pkg::S_SUBF: begin
        cmd.subf  = 1'b1;
        state_nxt = lcc_pkg::S_MULF;
      end
      lcc_pkg::S_MULF: begin
        cmd.mulf  = 1'b1;
        state_nxt = lcc_pkg::S_MULP;
      end
      lcc_pkg::S_MULP: begin
        cmd.mulp  = 1'b1;
        state_nxt = lcc_pkg::S_DONE;
      end
      lcc_pkg::S_DONE: begin
        // hold until the output register is free or being emptied
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = lcc_pkg::S_IDLE;
        end
      end
      default: state_nxt = lcc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lcc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `LCC_ASSERT(a_accept_starts, clk, rst_n, (in_tvalid && in_tready) |=> (state_r == lcc_pkg::S_STEP), "accepted transaction did not start the sequence")
  `LCC_NEVER(a_busy_no_ready, clk, rst_n, (state_r != lcc_pkg::S_IDLE) && in_tready, "ready raised while an item is in flight")
  `LCC_NEVER(a_no_overwrite, clk, rst_n, cmd.load_out && out_valid_r && !out_tready, "output register overwritten before it was taken")
  `LCC_ASSERT(a_load_sets_valid, clk, rst_n, cmd.load_out |=> (out_valid_r && state_r == lcc_pkg::S_IDLE), "result load did not raise valid")

endmodule

/* design/lcc_datapath.sv */
// Datapath of the load cell conditioner unit: configuration registers, filter and
// peak state, one shared multiplier, weight saturation and the output register.
// Depends on lcc_pkg and load_cell_conditioner_unit_defines.svh.
`include "load_cell_conditioner_unit_defines.svh"

module lcc_datapath (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lcc_pkg::lcc_cmd_t        cmd,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [31:0]              cfg_data,
  input  logic [1:0]               in_req_type,
  input  logic signed [31:0]       in_sample,
  output logic signed [31:0]       filtered_count,
  output logic                     glitch,
  output logic signed [47:0]       weight_q8,
  output logic signed [31:0]       peak_count,
  output logic signed [47:0]       peak_weight_q8
);

  // configuration
  logic signed [31:0] zero_offset_r;
  logic signed [31:0] scale_q24_r;
  logic [8:0]         alpha_q8_r;
  logic [30:0]        glitch_limit_r;

  // state and working registers
  logic signed [31:0] filter_r, filter_nxt;
  logic signed [31:0] peak_r, peak_nxt;
  logic [1:0]         req_r;
  logic signed [31:0] sample_r;
  logic signed [32:0] diff_r;
  logic               glitch_r;
  logic signed [32:0] opd_r;
  logic signed [64:0] prod_r;
  logic signed [47:0] wf_r;

  // output register
  logic signed [31:0] out_filtered_r;
  logic               out_glitch_r;
  logic signed [47:0] out_weight_r;
  logic signed [31:0] out_peak_r;
  logic signed [47:0] out_peak_weight_r;

  logic [8:0]         alpha_eff;
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] mul_p;
  logic [32:0]        diff_mag;
  logic               corr;
  logic [31:0]        filter_step;
  logic signed [31:0] opd_src;

  function automatic logic signed [47:0] sat48(input logic signed [64:0] p);
    logic [48:0] q;
    begin
      q = p[64:16];
      if (q[48] != q[47]) begin
        sat48 = q[48] ? {1'b1, {47{1'b0}}} : {1'b0, {47{1'b1}}};
      end else begin
        sat48 = q[47:0];
      end
    end
  endfunction

  // gain above one acts as one
  assign alpha_eff = alpha_q8_r[8] ? lcc_pkg::ALPHA_ONE : alpha_q8_r;

  assign mul_a = cmd.step ? diff_r : opd_r;
  assign mul_b = cmd.step ? $signed({23'b0, alpha_eff}) : scale_q24_r;
  assign mul_p = 65'(mul_a) * 65'(mul_b);

  assign diff_mag = diff_r[32] ? 33'(-diff_r) : 33'(diff_r);

  // floor shift plus one for a negative product with dropped bits: truncation toward zero
  assign corr        = prod_r[64] && (prod_r[7:0] != 8'd0);
  assign filter_step = filter_r + prod_r[39:8] + {31'b0, corr};

  assign opd_src = cmd.subf ? filter_r : peak_r;

  always_comb begin
    filter_nxt = filter_r;
    peak_nxt   = peak_r;
    case (req_r)
      lcc_pkg::REQ_NEW: begin
        if (!glitch_r) begin
          filter_nxt = filter_step;
          if (sample_r > peak_r) begin
            peak_nxt = sample_r;
          end
        end
      end
      lcc_pkg::REQ_PEAK_RST: peak_nxt = filter_r;
      lcc_pkg::REQ_RESEED: begin
        filter_nxt = sample_r;
        peak_nxt   = sample_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_offset_r  <= '0;
      scale_q24_r    <= lcc_pkg::SCALE_RESET;
      alpha_q8_r     <= lcc_pkg::ALPHA_RESET;
      glitch_limit_r <= lcc_pkg::LIMIT_RESET;
      filter_r       <= '0;
      peak_r         <= '0;
      req_r          <= lcc_pkg::REQ_NEW;
      glitch_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          lcc_pkg::CFG_ZERO_OFFSET:  zero_offset_r  <= cfg_data;
          lcc_pkg::CFG_SCALE_Q24:    scale_q24_r    <= cfg_data;
          lcc_pkg::CFG_ALPHA_Q8:     alpha_q8_r     <= cfg_data[8:0];
          lcc_pkg::CFG_GLITCH_LIMIT: glitch_limit_r <= cfg_data[30:0];
        endcase
      end
      if (cmd.accept) begin
        req_r <= in_req_type;
      end
      if (cmd.step) begin
        glitch_r <= (req_r == lcc_pkg::REQ_NEW) && (diff_mag > {2'b0, glitch_limit_r});
      end
      if (cmd.upd) begin
        filter_r <= filter_nxt;
        peak_r   <= peak_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r <= in_sample;
      diff_r   <= 33'(in_sample) - 33'(filter_r);
    end
    if (cmd.subf || cmd.mulf) begin
      opd_r <= 33'(opd_src) - 33'(zero_offset_r);
    end
    if (cmd.step || cmd.mulf || cmd.mulp) begin
      prod_r <= mul_p;
    end
    if (cmd.mulp) begin
      wf_r <= sat48(prod_r);
    end
    if (cmd.load_out) begin
      out_filtered_r    <= filter_r;
      out_glitch_r      <= glitch_r;
      out_weight_r      <= wf_r;
      out_peak_r        <= peak_r;
      out_peak_weight_r <= sat48(prod_r);
    end
  end

  assign filtered_count = out_filtered_r;
  assign glitch         = out_glitch_r;
  assign weight_q8      = out_weight_r;
  assign peak_count     = out_peak_r;
  assign peak_weight_q8 = out_peak_weight_r;

  `LCC_NEVER(a_glitch_only_new, clk, rst_n, cmd.upd && glitch_r && (req_r != lcc_pkg::REQ_NEW), "glitch flagged on a non-sample request")
  `LCC_ASSERT(a_glitch_holds, clk, rst_n, (cmd.upd && glitch_r) |=> ($stable(filter_r) && $stable(peak_r)), "rejected sample changed the state")
  `LCC_ASSERT(a_reseed_equal, clk, rst_n, (cmd.upd && req_r == lcc_pkg::REQ_RESEED) |=> (filter_r == peak_r), "reseed left filter and peak apart")

endmodule

/* design/load_cell_conditioner_unit.sv */
// Load cell conditioner: each transaction on the input stream carries a request kind
// in in_tuser (0 new sample, 1 reset peak to filtered value, 2 reseed filter and peak,
// 3 no change) and a signed count in in_tdata, and yields exactly one result transaction.
// From acceptance an item passes the step, update, subtract, multiply-filter and
// multiply-peak states before the done state loads its result into the output register
// once that register is free; the single shared multiplier runs the filter step and
// then the two weight products one after another. A new item is accepted once the
// previous one has reached the output register, so a result may wait there while the next is worked.
// Configuration writes are never stalled and must only happen while the unit is idle.
// Depends on lcc_pkg, lcc_ctrl and lcc_datapath.

module load_cell_conditioner_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // [31:0] sample
  input  logic [1:0]   in_tuser,   // [1:0] req_type
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] filtered_count, [79:32] weight_q8, [111:80] peak_count,
  // [159:112] peak_weight_q8
  output logic [159:0] out_tdata,
  output logic         out_tuser,  // [0] glitch
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  lcc_pkg::lcc_cmd_t  cmd;
  logic signed [31:0] filtered_count;
  logic               glitch;
  logic signed [47:0] weight_q8;
  logic signed [31:0] peak_count;
  logic signed [47:0] peak_weight_q8;

  assign cfg_ready = 1'b1;

  lcc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  lcc_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_req_type    (in_tuser),
    .in_sample      (in_tdata),
    .filtered_count (filtered_count),
    .glitch         (glitch),
    .weight_q8      (weight_q8),
    .peak_count     (peak_count),
    .peak_weight_q8 (peak_weight_q8)
  );

  assign out_tdata = {peak_weight_q8, peak_count, weight_q8, filtered_count};
  assign out_tuser = glitch;

endmodule
